// ===== sv/edge_envelope_tremolo_generator_assert.svh =====
// Assertion macros for the edge envelope tremolo generator.
// Included by eetg_back, the module that carries concurrent checks; relies on clk_i and rst_ni.
`ifndef EDGE_ENVELOPE_TREMOLO_GENERATOR_ASSERT_SVH
`define EDGE_ENVELOPE_TREMOLO_GENERATOR_ASSERT_SVH
`ifndef SYNTH
`define EETG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define EETG_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define EETG_ASSERT(lbl, prop, msg)
`define EETG_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== sv/eetg_pkg.sv =====
// Shared types and constants of the edge envelope tremolo generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package eetg_pkg;

  localparam int unsigned CountBits = 10;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 10;

  localparam logic [7:0] AmpMin = 8'd16;
  localparam logic [7:0] AmpMax = 8'd239;
  localparam logic [7:0] DurMin = 8'd6;
  localparam logic [7:0] DurMax = 8'd239;
  localparam logic [7:0] SilDur = 8'd250;
  localparam logic [7:0] SilMid = 8'd128;

  typedef enum logic [2:0] {
    CFG_REPEAT    = 3'd0,
    CFG_RAMP      = 3'd1,
    CFG_PLATEAU   = 3'd2,
    CFG_TREM_HALF = 3'd3,
    CFG_SIL_LEVEL = 3'd4,
    CFG_SIL_COUNT = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_RISE = 3'd1,
    PH_PLAT = 3'd2,
    PH_FALL = 3'd3,
    PH_SIL  = 3'd4
  } phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] init_amp_a;
    logic [7:0] init_amp_b;
    logic [7:0] init_dur_a;
    logic [7:0] init_dur_b;
    logic [7:0] amp_step_a;
    logic [7:0] amp_step_b;
    logic [7:0] dur_step_a;
    logic [7:0] dur_step_b;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_slot_t;

  typedef struct packed {
    logic [7:0] level;
    logic [7:0] duration;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } res_push_t;

endpackage

// ===== sv/eetg_front.sv =====
// Front end: accepts input beats, tags them as start or step and queues them.
// Depends on eetg_pkg.
`timescale 1ns / 1ps
module eetg_front
  import eetg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       cmd_i,
  input  logic [7:0] init_amp_a_i,
  input  logic [7:0] init_amp_b_i,
  input  logic [7:0] init_dur_a_i,
  input  logic [7:0] init_dur_b_i,
  input  logic [7:0] amp_step_a_i,
  input  logic [7:0] amp_step_b_i,
  input  logic [7:0] dur_step_a_i,
  input  logic [7:0] dur_step_b_i,
  output item_slot_t slot_o,
  input  logic       take_i
);

  item_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       wr_en, rd_en;
  item_t      item_in;

  always_comb begin
    item_in.kind       = cmd_i ? KIND_STEP : KIND_START;
    item_in.init_amp_a = init_amp_a_i;
    item_in.init_amp_b = init_amp_b_i;
    item_in.init_dur_a = init_dur_a_i;
    item_in.init_dur_b = init_dur_b_i;
    item_in.amp_step_a = amp_step_a_i;
    item_in.amp_step_b = amp_step_b_i;
    item_in.dur_step_a = dur_step_a_i;
    item_in.dur_step_b = dur_step_b_i;
  end

  assign full        = (count_q == 2'd2);
  assign wr_en       = push && !full;
  assign rd_en       = take_i && (count_q != 2'd0);
  assign slot_o.valid = (count_q != 2'd0);
  assign slot_o.item  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? ~rd_ptr_q : rd_ptr_q;
    unique case ({wr_en, rd_en})
      2'b10: count_d = count_q + 2'd1;
      2'b01: count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ===== sv/eetg_back.sv =====
// Back end: configuration registers, note sequencer and edge arithmetic.
// Depends on eetg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "edge_envelope_tremolo_generator_assert.svh"
module eetg_back
  import eetg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  item_slot_t          slot_i,
  output logic                take_o,
  input  logic                out_ready_i,
  output res_push_t           res_o
);

  typedef struct packed {
    phase_e               ph;
    logic [CountBits-1:0] left;
    logic                 clr_pos;
  } entry_t;

  // Configuration registers.
  logic [9:0] repeat_q, ramp_q, plateau_q, sil_count_q;
  logic [7:0] trem_half_q, sil_level_q;

  // Note state.
  phase_e               phase_q, phase_d;
  logic                 edge_q, edge_d;
  logic [CountBits-1:0] left_q, left_d;
  logic [CountBits-1:0] rep_q, rep_d;
  logic [9:0]           pos_q, pos_d;
  logic [7:0] start_amp_a_q, start_amp_a_d, start_amp_b_q, start_amp_b_d;
  logic [7:0] start_dur_a_q, start_dur_a_d, start_dur_b_q, start_dur_b_d;
  logic [7:0] astep_a_q, astep_a_d, astep_b_q, astep_b_d;
  logic [7:0] dstep_a_q, dstep_a_d, dstep_b_q, dstep_b_d;
  logic [7:0] amp_a_q, amp_a_d, amp_b_q, amp_b_d;
  logic [7:0] dur_a_q, dur_a_d, dur_b_q, dur_b_d;

  logic [CountBits-1:0] rep_cnt, ramp_cnt, plat_cnt, sil_cnt;
  logic                 ramp_nz, plat_nz, sil_nz, all_zero;
  entry_t               head, tail;
  logic                 tail_ok;

  logic [7:0]        amp_cur, dur_cur, astep, dstep;
  logic [8:0]        twice;
  logic [9:0]        quad;
  logic              trem_fwd, amp_up;
  logic [10:0]       pos_inc;
  logic [9:0]        pos_next;
  logic signed [9:0] amp_sum, dur_sum;
  logic [7:0]        amp_new, dur_new;
  logic [CountBits-1:0] left_dec, rep_dec;
  logic [7:0]        lvl, dur;

  function automatic logic [7:0] clamp8(logic signed [9:0] v, logic [7:0] lo,
                                        logic [7:0] hi);
    logic [7:0] r;
    if (v > $signed({2'b00, hi})) begin
      r = hi;
    end else if (v < $signed({2'b00, lo})) begin
      r = lo;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign take_o      = slot_i.valid && out_ready_i;

  assign rep_cnt  = CountBits'(repeat_q);
  assign ramp_cnt = CountBits'(ramp_q);
  assign plat_cnt = CountBits'(plateau_q);
  assign sil_cnt  = CountBits'(sil_count_q);
  assign ramp_nz  = (ramp_cnt != '0);
  assign plat_nz  = (plat_cnt != '0);
  assign sil_nz   = (sil_cnt != '0);
  assign all_zero = !ramp_nz && !plat_nz && !sil_nz;

  // First phase with work when a repeat begins.
  always_comb begin
    priority if (ramp_nz) begin
      head = '{ph: PH_RISE, left: ramp_cnt, clr_pos: 1'b0};
    end else if (plat_nz) begin
      head = '{ph: PH_PLAT, left: plat_cnt, clr_pos: 1'b1};
    end else begin
      head = '{ph: PH_SIL, left: sil_cnt, clr_pos: 1'b0};
    end
  end

  // Next phase with work inside the current repeat, if there is one.
  always_comb begin
    tail    = '{ph: PH_SIL, left: sil_cnt, clr_pos: 1'b0};
    tail_ok = 1'b0;
    unique case (phase_q)
      PH_RISE: begin
        priority if (plat_nz) begin
          tail    = '{ph: PH_PLAT, left: plat_cnt, clr_pos: 1'b1};
          tail_ok = 1'b1;
        end else if (ramp_nz) begin
          tail    = '{ph: PH_FALL, left: ramp_cnt, clr_pos: 1'b0};
          tail_ok = 1'b1;
        end else begin
          tail_ok = sil_nz;
        end
      end
      PH_PLAT: begin
        priority if (ramp_nz) begin
          tail    = '{ph: PH_FALL, left: ramp_cnt, clr_pos: 1'b0};
          tail_ok = 1'b1;
        end else begin
          tail_ok = sil_nz;
        end
      end
      PH_FALL: tail_ok = sil_nz;
      default: tail_ok = 1'b0;
    endcase
  end

  // Edge arithmetic: one shared adder for level and one for duration.
  always_comb begin
    amp_cur  = edge_q ? amp_b_q : amp_a_q;
    dur_cur  = edge_q ? dur_b_q : dur_a_q;
    astep    = edge_q ? astep_b_q : astep_a_q;
    dstep    = edge_q ? dstep_b_q : dstep_a_q;
    twice    = {trem_half_q, 1'b0};
    quad     = {trem_half_q, 2'b00};
    trem_fwd = ({1'b0, pos_q} < {2'b00, twice});
    pos_inc  = {1'b0, pos_q} + 11'd1;
    pos_next = (pos_inc >= {1'b0, quad}) ? 10'd0 : pos_inc[9:0];
    unique case (phase_q)
      PH_RISE: amp_up = !edge_q;
      PH_FALL: amp_up = edge_q;
      default: amp_up = !trem_fwd;
    endcase
    amp_sum = amp_up ? $signed({2'b00, amp_cur}) + $signed({2'b00, astep})
                     : $signed({2'b00, amp_cur}) - $signed({2'b00, astep});
    dur_sum = trem_fwd ? $signed({2'b00, dur_cur}) + $signed({2'b00, dstep})
                       : $signed({2'b00, dur_cur}) - $signed({2'b00, dstep});
    amp_new  = clamp8(amp_sum, AmpMin, AmpMax);
    dur_new  = clamp8(dur_sum, DurMin, DurMax);
    left_dec = edge_q ? (left_q - CountBits'(1)) : left_q;
    rep_dec  = rep_q - CountBits'(1);
  end

  always_comb begin
    phase_d       = phase_q;
    edge_d        = edge_q;
    left_d        = left_q;
    rep_d         = rep_q;
    pos_d         = pos_q;
    start_amp_a_d = start_amp_a_q;
    start_amp_b_d = start_amp_b_q;
    start_dur_a_d = start_dur_a_q;
    start_dur_b_d = start_dur_b_q;
    astep_a_d     = astep_a_q;
    astep_b_d     = astep_b_q;
    dstep_a_d     = dstep_a_q;
    dstep_b_d     = dstep_b_q;
    amp_a_d       = amp_a_q;
    amp_b_d       = amp_b_q;
    dur_a_d       = dur_a_q;
    dur_b_d       = dur_b_q;
    lvl           = amp_new;
    dur           = dur_cur;
    res_o         = '0;

    if (take_o) begin
      if (slot_i.item.kind == KIND_START) begin
        start_amp_a_d = slot_i.item.init_amp_a;
        start_amp_b_d = slot_i.item.init_amp_b;
        start_dur_a_d = slot_i.item.init_dur_a;
        start_dur_b_d = slot_i.item.init_dur_b;
        astep_a_d     = slot_i.item.amp_step_a;
        astep_b_d     = slot_i.item.amp_step_b;
        dstep_a_d     = slot_i.item.dur_step_a;
        dstep_b_d     = slot_i.item.dur_step_b;
        amp_a_d       = slot_i.item.init_amp_a;
        amp_b_d       = slot_i.item.init_amp_b;
        dur_a_d       = slot_i.item.init_dur_a;
        dur_b_d       = slot_i.item.init_dur_b;
        rep_d         = rep_cnt;
        pos_d         = '0;
        edge_d        = 1'b0;
        if (rep_cnt == '0 || all_zero) begin
          phase_d = PH_IDLE;
        end else begin
          phase_d = head.ph;
          left_d  = head.left;
        end
      end else if (phase_q != PH_IDLE) begin
        unique case (phase_q)
          PH_RISE, PH_FALL: begin
            if (edge_q) amp_b_d = amp_new;
            else        amp_a_d = amp_new;
          end
          PH_PLAT: begin
            if (edge_q) begin
              amp_b_d = amp_new;
              dur_b_d = dur_new;
            end else begin
              amp_a_d = amp_new;
              dur_a_d = dur_new;
            end
            dur   = dur_new;
            pos_d = pos_next;
          end
          default: begin
            lvl = edge_q ? SilMid : sil_level_q;
            dur = SilDur;
          end
        endcase

        edge_d = ~edge_q;
        left_d = left_dec;
        // A finished phase moves on to the next one that has work, or the
        // note wraps to a new repeat from the loaded start values, or ends.
        if (all_zero) begin
          phase_d = PH_IDLE;
        end else if (left_dec == '0) begin
          edge_d = 1'b0;
          if (tail_ok) begin
            phase_d = tail.ph;
            left_d  = tail.left;
            if (tail.clr_pos) pos_d = '0;
          end else begin
            rep_d = rep_dec;
            if (rep_dec == '0) begin
              phase_d = PH_IDLE;
            end else begin
              amp_a_d = start_amp_a_q;
              amp_b_d = start_amp_b_q;
              dur_a_d = start_dur_a_q;
              dur_b_d = start_dur_b_q;
              phase_d = head.ph;
              left_d  = head.left;
              if (head.clr_pos) pos_d = '0;
            end
          end
        end

        res_o.valid        = 1'b1;
        res_o.res.level    = lvl;
        res_o.res.duration = dur;
        res_o.res.last     = (phase_d == PH_IDLE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_q    <= 10'd1;
      ramp_q      <= 10'd4;
      plateau_q   <= 10'd8;
      trem_half_q <= 8'd1;
      sil_level_q <= 8'd128;
      sil_count_q <= 10'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_REPEAT:    repeat_q    <= cfg_data_i;
        CFG_RAMP:      ramp_q      <= cfg_data_i;
        CFG_PLATEAU:   plateau_q   <= cfg_data_i;
        CFG_TREM_HALF: trem_half_q <= cfg_data_i[7:0];
        CFG_SIL_LEVEL: sil_level_q <= cfg_data_i[7:0];
        CFG_SIL_COUNT: sil_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      edge_q  <= 1'b0;
      left_q  <= '0;
      rep_q   <= '0;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      edge_q  <= edge_d;
      left_q  <= left_d;
      rep_q   <= rep_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_amp_a_q <= start_amp_a_d;
    start_amp_b_q <= start_amp_b_d;
    start_dur_a_q <= start_dur_a_d;
    start_dur_b_q <= start_dur_b_d;
    astep_a_q     <= astep_a_d;
    astep_b_q     <= astep_b_d;
    dstep_a_q     <= dstep_a_d;
    dstep_b_q     <= dstep_b_d;
    amp_a_q       <= amp_a_d;
    amp_b_q       <= amp_b_d;
    dur_a_q       <= dur_a_d;
    dur_b_q       <= dur_b_d;
  end

  `EETG_ASSERT(a_active_has_work, (phase_q != PH_IDLE) |-> (left_q != '0), "active phase with no edges left")
  `EETG_ASSERT(a_last_ends_note, (res_o.valid && res_o.res.last) |=> (phase_q == PH_IDLE), "last beat did not end the note")
  `EETG_ASSERT(a_zero_repeat_idle, (take_o && slot_i.item.kind == KIND_START && rep_cnt == '0) |=> (phase_q == PH_IDLE), "zero repeat count started a note")
  `EETG_ASSERT_NEVER(a_no_result_overflow, res_o.valid && !out_ready_i, "result pushed into a full queue")

endmodule

// ===== sv/eetg_outq.sv =====
// Result queue: two entries between the sequencer and the pop side.
// Depends on eetg_pkg.
`timescale 1ns / 1ps
module eetg_outq
  import eetg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t in_i,
  output logic      ready_o,
  output logic      empty,
  input  logic      pop,
  output result_t   res_o
);

  result_t    entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       wr_en, rd_en;

  assign ready_o = (count_q != 2'd2);
  assign empty   = (count_q == 2'd0);
  assign wr_en   = in_i.valid && ready_o;
  assign rd_en   = pop && !empty;
  assign res_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? ~rd_ptr_q : rd_ptr_q;
    unique case ({wr_en, rd_en})
      2'b10: count_d = count_q + 2'd1;
      2'b01: count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= in_i.res;
    end
  end

endmodule

// ===== sv/edge_envelope_tremolo_generator.sv =====
// Top level of the edge envelope tremolo generator.
// Instantiates eetg_front, eetg_back and eetg_outq; depends on eetg_pkg.
//
// Usage:
//  - Input side is a queue: drive the item fields with push high; a beat is
//    taken when full is low. cmd 0 starts a note (loads levels, durations and
//    steps, no result); cmd 1 asks for the next (level, duration) pair.
//  - Result side is a queue: while empty is low the oldest pair sits on
//    level_o, duration_o and last_of_note_o; pop takes it.
//  - Configuration registers are written through cfg_valid_i/cfg_index_i/
//    cfg_data_i; cfg_ready_o is always high. Write them only when no beat is
//    in flight.
//  - With both queues empty, a step beat is held in the input queue and its
//    result is then registered in the result queue. Throughput is one beat
//    per cycle while the result queue is not full, set by the shared adders.
//  - A step with no note in progress, and every start beat, yields nothing.
//  - Reset empties both queues, leaves the sequencer idle and loads the
//    register defaults. If pop stays low, two results and then two input
//    beats are buffered before full rises.
`timescale 1ns / 1ps
module edge_envelope_tremolo_generator
  import eetg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                cmd_i,
  input  logic [7:0]          init_amp_a_i,
  input  logic [7:0]          init_amp_b_i,
  input  logic [7:0]          init_dur_a_i,
  input  logic [7:0]          init_dur_b_i,
  input  logic [7:0]          amp_step_a_i,
  input  logic [7:0]          amp_step_b_i,
  input  logic [7:0]          dur_step_a_i,
  input  logic [7:0]          dur_step_b_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          level_o,
  output logic [7:0]          duration_o,
  output logic                last_of_note_o
);

  item_slot_t slot;
  logic       take;
  logic       out_ready;
  res_push_t  res_push;
  result_t    head;

  eetg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .cmd_i        (cmd_i),
    .init_amp_a_i (init_amp_a_i),
    .init_amp_b_i (init_amp_b_i),
    .init_dur_a_i (init_dur_a_i),
    .init_dur_b_i (init_dur_b_i),
    .amp_step_a_i (amp_step_a_i),
    .amp_step_b_i (amp_step_b_i),
    .dur_step_a_i (dur_step_a_i),
    .dur_step_b_i (dur_step_b_i),
    .slot_o       (slot),
    .take_i       (take)
  );

  eetg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .slot_i      (slot),
    .take_o      (take),
    .out_ready_i (out_ready),
    .res_o       (res_push)
  );

  eetg_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (res_push),
    .ready_o (out_ready),
    .empty   (empty),
    .pop     (pop),
    .res_o   (head)
  );

  assign level_o        = head.level;
  assign duration_o     = head.duration;
  assign last_of_note_o = head.last;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the edge envelope tremolo generator.
// Needs eetg_pkg and the block's RTL; it computes the expected edge pairs itself
// and checks every result beat against them.
`timescale 1ns / 1ps
module tb;
  import eetg_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int          HoldCycles = 300;

  logic        clk = 1'b1;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  item_t       drv_item = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_e    cfg_index = CFG_REPEAT;
  logic [9:0]  cfg_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  level_o;
  logic [7:0]  duration_o;
  logic        last_of_note_o;

  item_t       pending_q[$];
  result_t     pairs_due[$];
  int          errors = 0;
  logic        beat_taken = 1'b0;

  // Sender shaping.
  bit          bursty = 1'b0;
  int          gap_left = 0;
  int          burst_left = 0;

  // Receiver shaping.
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          rate_left = 0;
  int          pop_pct = 100;

  // Register copies, at their reset values.
  logic [9:0]  reg_repeat = 10'd1;
  logic [9:0]  reg_ramp = 10'd4;
  logic [9:0]  reg_plateau = 10'd8;
  logic [7:0]  reg_trem = 8'd1;
  logic [7:0]  reg_sil_lvl = 8'd128;
  logic [9:0]  reg_sil_cnt = 10'd0;

  // Envelope state; index 0 is edge A, index 1 is edge B.
  logic [7:0]  base_amp [2] = '{8'd0, 8'd0};
  logic [7:0]  base_dur [2] = '{8'd0, 8'd0};
  logic [7:0]  amp_inc [2] = '{8'd0, 8'd0};
  logic [7:0]  dur_inc [2] = '{8'd0, 8'd0};
  logic [7:0]  lvl_now [2] = '{8'd0, 8'd0};
  logic [7:0]  dur_now [2] = '{8'd0, 8'd0};
  phase_e      cur_phase = PH_IDLE;
  logic        which_edge = 1'b0;
  logic [9:0]  iters_left = '0;
  logic [9:0]  reps_left = '0;
  logic [9:0]  trem_step = '0;

  edge_envelope_tremolo_generator dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .cmd_i          (drv_item.kind),
    .init_amp_a_i   (drv_item.init_amp_a),
    .init_amp_b_i   (drv_item.init_amp_b),
    .init_dur_a_i   (drv_item.init_dur_a),
    .init_dur_b_i   (drv_item.init_dur_b),
    .amp_step_a_i   (drv_item.amp_step_a),
    .amp_step_b_i   (drv_item.amp_step_b),
    .dur_step_a_i   (drv_item.dur_step_a),
    .dur_step_b_i   (drv_item.dur_step_b),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .empty          (empty),
    .pop            (pop),
    .level_o        (level_o),
    .duration_o     (duration_o),
    .last_of_note_o (last_of_note_o)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [7:0] clamp_to(int v, int lo, int hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[7:0];
  endfunction

  task automatic restart_envelope();
    lvl_now = base_amp;
    dur_now = base_dur;
    cur_phase = PH_RISE;
    iters_left = reg_ramp;
    which_edge = 1'b0;
  endtask

  // Walk past phases whose count is used up so that idle means nothing pending.
  task automatic skip_spent_phases();
    if (reg_ramp == 0 && reg_plateau == 0 && reg_sil_cnt == 0) cur_phase = PH_IDLE;
    while (cur_phase != PH_IDLE && iters_left == 0) begin
      which_edge = 1'b0;
      case (cur_phase)
        PH_RISE: begin
          cur_phase = PH_PLAT;
          iters_left = reg_plateau;
          trem_step = '0;
        end
        PH_PLAT: begin
          cur_phase = PH_FALL;
          iters_left = reg_ramp;
        end
        PH_FALL: begin
          cur_phase = PH_SIL;
          iters_left = reg_sil_cnt;
        end
        default: begin
          reps_left = reps_left - 10'd1;
          if (reps_left == 0) cur_phase = PH_IDLE;
          else restart_envelope();
        end
      endcase
    end
  endtask

  task automatic next_edge_pair(input item_t it);
    result_t r;
    int      e;
    int      a;
    int      d;
    int      twice;
    int      pos;
    logic    up;
    r = '0;
    if (it.kind == KIND_START) begin
      base_amp[0] = it.init_amp_a;
      base_amp[1] = it.init_amp_b;
      base_dur[0] = it.init_dur_a;
      base_dur[1] = it.init_dur_b;
      amp_inc[0] = it.amp_step_a;
      amp_inc[1] = it.amp_step_b;
      dur_inc[0] = it.dur_step_a;
      dur_inc[1] = it.dur_step_b;
      reps_left = reg_repeat;
      trem_step = '0;
      if (reps_left == 0) cur_phase = PH_IDLE;
      else restart_envelope();
      skip_spent_phases();
    end else if (cur_phase != PH_IDLE) begin
      e = int'(which_edge);
      case (cur_phase)
        PH_RISE, PH_FALL: begin
          up = (cur_phase == PH_RISE) ? (which_edge == 1'b0) : (which_edge == 1'b1);
          a = up ? int'(lvl_now[e]) + int'(amp_inc[e]) : int'(lvl_now[e]) - int'(amp_inc[e]);
          lvl_now[e] = clamp_to(a, int'(AmpMin), int'(AmpMax));
          r.level = lvl_now[e];
          r.duration = dur_now[e];
        end
        PH_PLAT: begin
          a = int'(lvl_now[e]);
          d = int'(dur_now[e]);
          twice = 2 * int'(reg_trem);
          pos = int'(trem_step);
          // First 2T edges stretch and soften, the next 2T undo it.
          if (pos < twice) begin
            d = d + int'(dur_inc[e]);
            a = a - int'(amp_inc[e]);
          end
          if (pos > twice - 1) begin
            d = d - int'(dur_inc[e]);
            a = a + int'(amp_inc[e]);
          end
          pos = pos + 1;
          if (pos > twice * 2 - 1) pos = 0;
          trem_step = pos[9:0];
          lvl_now[e] = clamp_to(a, int'(AmpMin), int'(AmpMax));
          dur_now[e] = clamp_to(d, int'(DurMin), int'(DurMax));
          r.level = lvl_now[e];
          r.duration = dur_now[e];
        end
        default: begin
          r.level = which_edge ? SilMid : reg_sil_lvl;
          r.duration = SilDur;
        end
      endcase
      which_edge = ~which_edge;
      if (!which_edge) iters_left = iters_left - 10'd1;
      skip_spent_phases();
      r.last = (cur_phase == PH_IDLE);
      pairs_due.push_back(r);
    end
  endtask

  task automatic flag(string what, int want, int got);
    $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
    errors++;
  endtask

  // Input acceptance and result checking, both sampled at the rising edge.
  always @(posedge clk) begin
    result_t want;
    beat_taken = rst_n && push && !full;
    if (beat_taken) next_edge_pair(drv_item);
    if (rst_n && pop && !empty) begin
      if (pairs_due.size() == 0) begin
        $display("%0t: result expected none, actual level %0d duration %0d last %0d",
                 $time, level_o, duration_o, last_of_note_o);
        errors++;
      end else begin
        want = pairs_due.pop_front();
        if (level_o !== want.level)
          flag("level", int'(want.level), int'(level_o));
        if (duration_o !== want.duration)
          flag("duration", int'(want.duration), int'(duration_o));
        if (last_of_note_o !== want.last)
          flag("last_of_note", int'(want.last), int'(last_of_note_o));
      end
    end
  end

  // Sender: bursts of beats separated by random gaps when bursty is set.
  always @(negedge clk) begin
    item_t nxt;
    logic  nxt_push;
    nxt = drv_item;
    nxt_push = push;
    if (!push || beat_taken) begin
      nxt_push = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        nxt = pending_q.pop_front();
        nxt_push = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else if (bursty) begin
          burst_left = $urandom_range(0, 12);
          gap_left = $urandom_range(0, 6);
        end
      end
    end
    drv_item <= nxt;
    push <= nxt_push;
  end

  // Receiver: a pop rate that changes every so often, plus the long hold-off.
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HoldCycles;
    end
    if (rate_left == 0) begin
      rate_left = $urandom_range(32, 256);
      case ($urandom_range(0, 3))
        0: pop_pct = 100;
        1: pop_pct = 70;
        2: pop_pct = 35;
        default: pop_pct = 8;
      endcase
    end else begin
      rate_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(1, 100) <= pop_pct);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [9:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_REPEAT:    reg_repeat = val;
      CFG_RAMP:      reg_ramp = val;
      CFG_PLATEAU:   reg_plateau = val;
      CFG_TREM_HALF: reg_trem = val[7:0];
      CFG_SIL_LEVEL: reg_sil_lvl = val[7:0];
      CFG_SIL_COUNT: reg_sil_cnt = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(logic [9:0] rep, logic [9:0] ramp, logic [9:0] plat,
                              logic [9:0] trem, logic [9:0] sil_lvl, logic [9:0] sil_cnt);
    write_reg(CFG_REPEAT, rep);
    write_reg(CFG_RAMP, ramp);
    write_reg(CFG_PLATEAU, plat);
    write_reg(CFG_TREM_HALF, trem);
    write_reg(CFG_SIL_LEVEL, sil_lvl);
    write_reg(CFG_SIL_COUNT, sil_cnt);
  endtask

  // Start items cause no result, so the wait runs on past the last expected pair.
  task automatic wait_drained();
    do @(posedge clk); while (pending_q.size() != 0 || push || pairs_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic item_t make_item(kind_e k);
    item_t it;
    it.kind = k;
    it.init_amp_a = rand_byte();
    it.init_amp_b = rand_byte();
    it.init_dur_a = rand_byte();
    it.init_dur_b = rand_byte();
    it.amp_step_a = rand_byte();
    it.amp_step_b = rand_byte();
    it.dur_step_a = rand_byte();
    it.dur_step_b = rand_byte();
    return it;
  endfunction

  function automatic item_t fill_item(kind_e k, logic [7:0] v);
    return {k, {8{v}}};
  endfunction

  initial begin
    int unsigned cycles_run;
    cycles_run = 0;
    while (cycles_run < CycleLimit) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int made;
    int note_len;
    int n;
    int k;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Short note with a zero tremolo period; all-ones fields drive both level clamps and the duration floor.
    // A step before any start and one after the note's end give nothing.
    program_regs(10'd1, 10'd1, 10'd2, 10'd0, 10'd255, 10'd1);
    pending_q.push_back(fill_item(KIND_STEP, 8'h5a));
    pending_q.push_back(fill_item(KIND_START, 8'hff));
    repeat (11) pending_q.push_back(fill_item(KIND_STEP, 8'h00));
    wait_drained();

    // Zero repeats: the note is empty.
    program_regs(10'd0, 10'd3, 10'd3, 10'd1, 10'd0, 10'd1);
    pending_q.push_back(fill_item(KIND_START, 8'h3c));
    pending_q.push_back(fill_item(KIND_STEP, 8'hc3));
    wait_drained();

    // Every phase count zero: also empty.
    program_regs(10'd2, 10'd0, 10'd0, 10'd0, 10'd17, 10'd0);
    pending_q.push_back(fill_item(KIND_START, 8'h81));
    pending_q.push_back(fill_item(KIND_STEP, 8'h7e));
    wait_drained();

    // Largest settings; the note is far too long to finish, the next start aborts it.
    program_regs(10'd1023, 10'd1023, 10'd1023, 10'd255, 10'd0, 10'd1023);
    pending_q.push_back(fill_item(KIND_START, 8'h00));
    repeat (6) pending_q.push_back(fill_item(KIND_STEP, 8'hff));
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      // The pass with the long hold-off always has results to back up.
      program_regs((p != 1 && $urandom_range(0, 19) == 0) ? 10'd0
                                                           : 10'($urandom_range(1, 3)),
                   10'($urandom_range((p == 1) ? 1 : 0, 5)), 10'($urandom_range(0, 10)),
                   ($urandom_range(0, 9) == 0) ? 10'd255 : 10'($urandom_range(0, 3)),
                   10'($urandom_range(0, 1023)), 10'($urandom_range(0, 3)));
      bursty = (p > 1) && ($urandom_range(0, 3) != 0);
      if (reg_repeat == 0 || (reg_ramp == 0 && reg_plateau == 0 && reg_sil_cnt == 0))
        note_len = 0;
      else
        note_len = int'(reg_repeat) * 2 * (2 * int'(reg_ramp) + int'(reg_plateau) +
                                           int'(reg_sil_cnt));
      made = 0;
      while (made < 250) begin
        if (made == 0 || $urandom_range(0, 99) < 85) begin
          // A whole note, sometimes cut short by the next start, sometimes overrun.
          n = note_len + $urandom_range(0, 2);
          if ($urandom_range(0, 9) == 0) n = $urandom_range(0, note_len);
          pending_q.push_back(make_item(KIND_START));
          for (int i = 0; i < n; i++) pending_q.push_back(make_item(KIND_STEP));
          made += 1 + ((n < note_len) ? n : note_len);
        end else begin
          k = $urandom_range(1, 4);
          repeat (k) pending_q.push_back(make_item(kind_e'($urandom_range(0, 1))));
        end
      end
      // Hold the result side while the sender keeps offering, so both queues fill.
      if (p == 1) hold_asks++;
      wait_drained();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
